// ===== rtl/sfdl_pkg.sv =====
// Shared types and constants for the smoothed fractional delay line.
`timescale 1ns / 1ps
`default_nettype none

package sfdl_pkg;

	localparam int NUM_CH     = 2;
	localparam int FRAC_W     = 16;
	localparam int ROUND_HALF = 32768;

	typedef logic [31:0] delay_t;
	typedef logic [16:0] len_t;
	typedef logic [15:0] idx_t;
	typedef logic [15:0] frac_t;
	typedef logic [15:0] maxd_t;
	typedef logic [16:0] rate_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [16:0] cfg_data_t;

	localparam rate_t RATE_ONE = 17'h10000;

	// configuration register indexes
	localparam cfg_idx_t REG_MAX_DELAY = 2'd0;
	localparam cfg_idx_t REG_RATE      = 2'd1;
	localparam cfg_idx_t REG_SMOOTH_EN = 2'd2;

	// reset values of the configuration registers
	localparam maxd_t RST_MAX_DELAY = 16'hFFFF;
	localparam rate_t RST_RATE      = 17'h10000;

	// where an interpolation tap takes its sample from
	typedef logic [1:0] src_t;
	localparam src_t SRC_ZERO = 2'd0;
	localparam src_t SRC_MEM  = 2'd1;
	localparam src_t SRC_NEW  = 2'd2;

	// one strobe for the frame acceptance and for each step before the output load
	typedef struct packed {
		logic accept;
		logic mul;
		logic upd;
		logic pos;
		logic wrap;
		logic rd;
		logic dif;
		logic mac;
	} sfdl_stage_t;

	// read and write command from the delay control to every lane
	typedef struct packed {
		idx_t  wr_idx;
		idx_t  idx_a;
		idx_t  idx_b;
		src_t  src_a;
		src_t  src_b;
		frac_t frac;
	} sfdl_rd_t;

endpackage

`default_nettype wire

// ===== rtl/sfdl_delay_ctl.sv =====
// Delay smoother, clamp, read position and write pointer for all lanes.
`timescale 1ns / 1ps
`default_nettype none

module sfdl_delay_ctl #(
	parameter int STORE_DEPTH = 65536
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire sfdl_pkg::sfdl_stage_t stg,
	input  wire  [31:0]          target,
	input  wire                  last,
	input  wire  [15:0]          max_delay,
	input  wire  [16:0]          rate,
	input  wire                  smooth_en,
	output sfdl_pkg::sfdl_rd_t   rd
);

	localparam sfdl_pkg::len_t LEN_CAP = (STORE_DEPTH > 65536) ?
		sfdl_pkg::len_t'(65536) : sfdl_pkg::len_t'(STORE_DEPTH);

	// control state
	sfdl_pkg::delay_t smoothed_q;
	logic             primed_q;
	sfdl_pkg::idx_t   wp_q;
	sfdl_pkg::len_t   fill_q;

	// frame pipeline
	sfdl_pkg::delay_t target_q;
	logic             last_q;
	sfdl_pkg::delay_t base_s1;
	sfdl_pkg::delay_t mag_s1;
	logic             up_s1;
	logic [48:0]      prod_s2;
	sfdl_pkg::delay_t d_s3;
	sfdl_pkg::len_t   len_s3;
	sfdl_pkg::idx_t   wp_s3;
	logic [34:0]      pos_s4;
	sfdl_pkg::idx_t   i1_s5;
	sfdl_pkg::frac_t  frac_s5;

	sfdl_pkg::delay_t s_eff;
	logic             up_in;
	sfdl_pkg::delay_t mag_in;
	sfdl_pkg::rate_t  rate_sat;
	sfdl_pkg::delay_t delta;
	sfdl_pkg::delay_t s_new;
	sfdl_pkg::delay_t d_raw;
	sfdl_pkg::delay_t maxq;
	sfdl_pkg::delay_t d_cl;
	sfdl_pkg::len_t   len_raw;
	sfdl_pkg::len_t   len_c;
	sfdl_pkg::idx_t   wp_eff;
	logic [17:0]      pos_base;
	logic [34:0]      pos_full;
	logic [17:0]      pos_hi;
	sfdl_pkg::idx_t   i1_c;
	sfdl_pkg::len_t   i1_inc;
	sfdl_pkg::idx_t   i2_c;
	sfdl_pkg::len_t   wp_inc;

	function automatic sfdl_pkg::src_t pick_src(input sfdl_pkg::idx_t idx,
			input sfdl_pkg::idx_t wr, input sfdl_pkg::len_t fill);
		if (idx == wr) begin
			return sfdl_pkg::SRC_NEW;
		end else if ({1'b0, idx} < fill) begin
			return sfdl_pkg::SRC_MEM;
		end else begin
			return sfdl_pkg::SRC_ZERO;
		end
	endfunction

	always_comb begin
		// first frame after reset starts the smoother at the target
		s_eff    = primed_q ? smoothed_q : target;
		up_in    = (target >= s_eff);
		mag_in   = up_in ? (target - s_eff) : (s_eff - target);
		rate_sat = (rate > sfdl_pkg::RATE_ONE) ? sfdl_pkg::RATE_ONE : rate;

		delta = prod_s2[47:16];
		s_new = up_s1 ? (base_s1 + delta) : (base_s1 - delta);
		d_raw = smooth_en ? s_new : target_q;
		maxq  = {max_delay, 16'h0000};
		d_cl  = (d_raw > maxq) ? maxq : d_raw;

		len_raw = {1'b0, max_delay} + 17'd1;
		len_c   = (len_raw > LEN_CAP) ? LEN_CAP : len_raw;
		wp_eff  = ({1'b0, wp_q} >= len_c) ? '0 : wp_q;

		pos_base = {2'b00, wp_s3} + {1'b0, len_s3};
		pos_full = {1'b0, pos_base, 16'h0000} - {3'b000, d_s3};

		// a borrow wraps the position far out of range: it then reads entry zero
		pos_hi = pos_s4[33:16];
		if (pos_s4[34]) begin
			i1_c = '0;
		end else if (pos_hi >= {1'b0, len_s3}) begin
			i1_c = sfdl_pkg::idx_t'(pos_hi - {1'b0, len_s3});
		end else begin
			i1_c = sfdl_pkg::idx_t'(pos_hi);
		end

		i1_inc = {1'b0, i1_s5} + 17'd1;
		i2_c   = (i1_inc == len_s3) ? '0 : i1_inc[15:0];
		wp_inc = {1'b0, wp_s3} + 17'd1;
	end

	always_ff @(posedge clk) begin
		if (stg.accept) begin
			target_q <= target;
			last_q   <= last;
			base_s1  <= s_eff;
			mag_s1   <= mag_in;
			up_s1    <= up_in;
		end
		if (stg.mul) begin
			prod_s2 <= 49'(mag_s1 * rate_sat) + 49'(sfdl_pkg::ROUND_HALF);
		end
		if (stg.upd) begin
			d_s3   <= d_cl;
			len_s3 <= len_c;
			wp_s3  <= wp_eff;
		end
		if (stg.pos) begin
			pos_s4 <= pos_full;
		end
		if (stg.wrap) begin
			i1_s5   <= i1_c;
			frac_s5 <= pos_s4[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			primed_q   <= 1'b0;
			wp_q       <= '0;
			fill_q     <= '0;
		end else begin
			if (stg.upd) begin
				primed_q <= 1'b1;
				if (last_q) begin
					smoothed_q <= d_cl;
				end else if (smooth_en) begin
					smoothed_q <= s_new;
				end
			end
			if (stg.rd) begin
				wp_q <= (wp_inc == len_s3) ? '0 : wp_inc[15:0];
				// writes fill the store from entry zero upward
				if ({1'b0, wp_s3} == fill_q) begin
					fill_q <= fill_q + 17'd1;
				end
			end
		end
	end

	always_comb begin
		rd.wr_idx = wp_s3;
		rd.idx_a  = i1_s5;
		rd.idx_b  = i2_c;
		rd.src_a  = pick_src(i1_s5, wp_s3, fill_q);
		rd.src_b  = pick_src(i2_c, wp_s3, fill_q);
		rd.frac   = frac_s5;
	end

endmodule

`default_nettype wire

// ===== rtl/sfdl_lane.sv =====
// One channel lane: history memory and linear interpolation.
`timescale 1ns / 1ps
`default_nettype none

module sfdl_lane #(
	parameter int STORE_DEPTH = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  wire                          clk,
	input  wire sfdl_pkg::sfdl_stage_t   stg,
	input  wire sfdl_pkg::sfdl_rd_t      rd,
	input  wire signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int DW = SAMPLE_BITS + 1;
	localparam int PW = SAMPLE_BITS + 18;
	localparam int QW = PW - 16;
	localparam int SW = SAMPLE_BITS + 3;
	localparam logic signed [PW-1:0] RND  = PW'(sfdl_pkg::ROUND_HALF);
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = SW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	logic signed [SAMPLE_BITS-1:0] mem [0:STORE_DEPTH-1];

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] ra_s6;
	logic signed [SAMPLE_BITS-1:0] rb_s6;
	sfdl_pkg::src_t                src_a_s6;
	sfdl_pkg::src_t                src_b_s6;
	logic signed [SAMPLE_BITS-1:0] a_s7;
	logic signed [DW-1:0]          diff_s7;
	logic signed [SAMPLE_BITS-1:0] a_s8;
	logic signed [PW-1:0]          prod_s8;

	logic signed [SAMPLE_BITS-1:0] a_c;
	logic signed [SAMPLE_BITS-1:0] b_c;
	logic signed [PW-1:0]          prod_c;
	logic signed [QW-1:0]          q_c;
	logic signed [SW-1:0]          sum_c;

	function automatic logic signed [SAMPLE_BITS-1:0] tap(input sfdl_pkg::src_t src,
			input logic signed [SAMPLE_BITS-1:0] stored,
			input logic signed [SAMPLE_BITS-1:0] fresh);
		case (src)
			sfdl_pkg::SRC_MEM: return stored;
			sfdl_pkg::SRC_NEW: return fresh;
			default:           return '0;
		endcase
	endfunction

	always_ff @(posedge clk) begin
		if (stg.rd) begin
			mem[AW'(rd.wr_idx)] <= sample_q;
			ra_s6 <= mem[AW'(rd.idx_a)];
			rb_s6 <= mem[AW'(rd.idx_b)];
		end
	end

	always_comb begin
		a_c    = tap(src_a_s6, ra_s6, sample_q);
		b_c    = tap(src_b_s6, rb_s6, sample_q);
		prod_c = diff_s7 * $signed({1'b0, rd.frac}) + RND;
		q_c    = prod_s8[PW-1:16];
		sum_c  = a_s8 + q_c;
		if (sum_c > SMAX) begin
			result = SMAX[SAMPLE_BITS-1:0];
		end else if (sum_c < SMIN) begin
			result = SMIN[SAMPLE_BITS-1:0];
		end else begin
			result = sum_c[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stg.accept) begin
			sample_q <= sample;
		end
		if (stg.rd) begin
			src_a_s6 <= rd.src_a;
			src_b_s6 <= rd.src_b;
		end
		if (stg.dif) begin
			a_s7    <= a_c;
			diff_s7 <= b_c - a_c;
		end
		if (stg.mac) begin
			a_s8    <= a_s7;
			prod_s8 <= prod_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/smoothed_fractional_delay_line.sv =====
// Top level of the two-channel smoothed fractional delay line.
// Input channel: in_valid / in_stall, one frame per transfer: one sample per
// channel, a Q16.16 delay target and a block-end flag. Output channel:
// out_valid / out_stall, one frame of interpolated samples per input frame.
// Configuration: cfg_valid / cfg_ready (always ready); cfg_index 0 = maximum
// delay, 1 = smoothing rate, 2 = smoothing enable; other indexes are ignored.
// The frame walks through a sequence of steps (smoother multiply, update and
// clamp, read position, wrap, memory access, two interpolation steps, output
// load) and the next frame enters when the sequence is back at idle.
// Reset: clears the smoother, the write pointer and the store fill count;
// unwritten store entries read as zero, so no clearing pass is needed.
// A stalled result holds in the output register; the sequence waits at its
// last step until the register frees up, then accepts the next frame.
`timescale 1ns / 1ps
`default_nettype none

module smoothed_fractional_delay_line #(
	parameter int STORE_DEPTH = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire signed [SAMPLE_BITS-1:0]  sample_ch0,
	input  wire signed [SAMPLE_BITS-1:0]  sample_ch1,
	input  wire  [31:0]                   delay_target,
	input  wire                           block_last,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_ch0,
	output logic signed [SAMPLE_BITS-1:0] out_ch1,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [1:0]                    cfg_index,
	input  wire  [16:0]                   cfg_data
);

	// sequence steps
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_UPD  = 4'd2;
	localparam logic [3:0] ST_POS  = 4'd3;
	localparam logic [3:0] ST_WRAP = 4'd4;
	localparam logic [3:0] ST_RD   = 4'd5;
	localparam logic [3:0] ST_DIF  = 4'd6;
	localparam logic [3:0] ST_MAC  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;

	// configuration registers
	sfdl_pkg::maxd_t max_delay_q;
	sfdl_pkg::rate_t rate_q;
	logic            smooth_en_q;

	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out0_q;
	logic signed [SAMPLE_BITS-1:0] out1_q;

	sfdl_pkg::sfdl_stage_t stg;
	sfdl_pkg::sfdl_rd_t    rd;
	logic                  out_free;

	logic signed [SAMPLE_BITS-1:0] lane_in  [sfdl_pkg::NUM_CH];
	logic signed [SAMPLE_BITS-1:0] lane_out [sfdl_pkg::NUM_CH];

	assign lane_in[0] = sample_ch0;
	assign lane_in[1] = sample_ch1;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_ch0   = out0_q;
	assign out_ch1   = out1_q;

	// the output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		stg.accept = in_valid && !in_stall;
		stg.mul    = (state_q == ST_MUL);
		stg.upd    = (state_q == ST_UPD);
		stg.pos    = (state_q == ST_POS);
		stg.wrap   = (state_q == ST_WRAP);
		stg.rd     = (state_q == ST_RD);
		stg.dif    = (state_q == ST_DIF);
		stg.mac    = (state_q == ST_MAC);
	end

	sfdl_delay_ctl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stg       (stg),
		.target    (delay_target),
		.last      (block_last),
		.max_delay (max_delay_q),
		.rate      (rate_q),
		.smooth_en (smooth_en_q),
		.rd        (rd)
	);

	// one lane per channel, all driven by the same read command
	for (genvar c = 0; c < sfdl_pkg::NUM_CH; c++) begin : g_lane
		sfdl_lane #(
			.STORE_DEPTH(STORE_DEPTH),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk    (clk),
			.stg    (stg),
			.rd     (rd),
			.sample (lane_in[c]),
			.result (lane_out[c])
		);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delay_q <= sfdl_pkg::RST_MAX_DELAY;
			rate_q      <= sfdl_pkg::RST_RATE;
			smooth_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfdl_pkg::REG_MAX_DELAY: max_delay_q <= cfg_data[15:0];
				sfdl_pkg::REG_RATE:      rate_q      <= cfg_data;
				sfdl_pkg::REG_SMOOTH_EN: smooth_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequence: advance one step per cycle, hold at the last step while the
	// output register is still occupied by a stalled result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (stg.accept) begin
					state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_POS;
				ST_POS:  state_q <= ST_WRAP;
				ST_WRAP: state_q <= ST_RD;
				ST_RD:   state_q <= ST_DIF;
				ST_DIF:  state_q <= ST_MAC;
				ST_MAC:  state_q <= ST_OUT;
				ST_OUT: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// merge the lane results into the output register
	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out0_q <= lane_out[0];
			out1_q <= lane_out[1];
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_smoothed_fractional_delay_line.sv =====
// Self-checking testbench for the smoothed fractional delay line.
`timescale 1ns / 1ps

module tb_smoothed_fractional_delay_line;

	localparam int SAMPLE_W     = 24;
	localparam int HIST_LEN     = 65536;
	localparam int SETTLE       = 12;     // a little longer than the frame sequence
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_FRAMES = 128;
	localparam int LONG_HOLD    = 90;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t PEAK_POS = 24'sh7FFFFF;
	localparam sample_t PEAK_NEG = 24'sh800000;

	typedef struct {
		sample_t          ch0;
		sample_t          ch1;
		sfdl_pkg::delay_t target;
		logic             last;
	} frame_t;

	typedef struct {
		sample_t ch0;
		sample_t ch1;
	} tap_out_t;

	// Shadow copy of the delay line: keeps its own history, write pointer and
	// smoother, and queues the output frame that each accepted frame must give.
	class delay_line_shadow;
		int               hist [sfdl_pkg::NUM_CH][HIST_LEN];
		int unsigned      max_frames;
		sfdl_pkg::rate_t  glide_rate;
		bit               glide_on;
		int unsigned      wr_pos;
		sfdl_pkg::delay_t glide_q;
		bit               primed;
		tap_out_t         outputs_due[$];
		int               errors;

		function new();
			max_frames = sfdl_pkg::RST_MAX_DELAY;
			glide_rate = sfdl_pkg::RST_RATE;
			glide_on   = 1'b1;
			wr_pos     = 0;
			glide_q    = '0;
			primed     = 1'b0;
			errors     = 0;
		endfunction

		function void configure(sfdl_pkg::cfg_idx_t idx, sfdl_pkg::cfg_data_t data);
			case (idx)
				sfdl_pkg::REG_MAX_DELAY: max_frames = data[15:0];
				sfdl_pkg::REG_RATE:      glide_rate = data;
				sfdl_pkg::REG_SMOOTH_EN: glide_on   = data[0];
				default: ;
			endcase
		endfunction

		// One smoother step, rounded to nearest with ties away from zero.
		function sfdl_pkg::delay_t glide(sfdl_pkg::delay_t s, sfdl_pkg::delay_t t);
			longint unsigned gap, r, step;
			r = (glide_rate > sfdl_pkg::RATE_ONE) ? 64'd65536 : 64'(glide_rate);
			if (t >= s) begin
				gap  = t - s;
				step = (gap * r + 32768) >> 16;
				return s + step[31:0];
			end
			gap  = s - t;
			step = (gap * r + 32768) >> 16;
			return s - step[31:0];
		endfunction

		function sample_t blend(int a, int b, longint unsigned f);
			longint acc;
			acc = longint'(a) * (65536 - longint'(f)) + longint'(b) * longint'(f) + 32768;
			acc = acc >>> 16;
			if (acc > PEAK_POS)
				acc = PEAK_POS;
			if (acc < PEAK_NEG)
				acc = PEAK_NEG;
			return acc[SAMPLE_W-1:0];
		endfunction

		function void take_frame(frame_t fr);
			longint unsigned span, ceiling, d, pos, i1, i2, f;
			tap_out_t o;
			span = max_frames;
			span = span + 1;
			if (span > HIST_LEN)
				span = HIST_LEN;
			if (wr_pos >= span)
				wr_pos = 0;
			if (glide_on) begin
				if (!primed)
					glide_q = fr.target;
				glide_q = glide(glide_q, fr.target);
				d = glide_q;
			end else begin
				d = fr.target;
			end
			primed  = 1'b1;
			ceiling = max_frames;
			ceiling = ceiling << 16;
			if (d > ceiling)
				d = ceiling;
			pos = wr_pos;
			pos = (pos << 16) + (span << 16) - d;
			if (pos >= (span << 16))
				pos -= span << 16;
			i1 = pos >> 16;
			f  = pos & 64'hFFFF;
			if (i1 >= span)
				i1 = 0;
			i2 = i1 + 1;
			if (i2 >= span)
				i2 = 0;
			hist[0][wr_pos] = fr.ch0;
			hist[1][wr_pos] = fr.ch1;
			o.ch0 = blend(hist[0][i1], hist[0][i2], f);
			o.ch1 = blend(hist[1][i1], hist[1][i2], f);
			outputs_due.push_back(o);
			wr_pos = 32'((64'(wr_pos) + 64'd1) % span);
			if (fr.last)
				glide_q = d[31:0];
		endfunction

		function void check_output(sample_t ch0, sample_t ch1);
			tap_out_t want;
			if (outputs_due.size() == 0) begin
				$error("output transfer with no frame pending");
				errors++;
				return;
			end
			want = outputs_due.pop_front();
			if (ch0 !== want.ch0) begin
				$error("out_ch0 expected %0d got %0d", want.ch0, ch0);
				errors++;
			end
			if (ch1 !== want.ch1) begin
				$error("out_ch1 expected %0d got %0d", want.ch1, ch1);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	sample_t             sample_ch0;
	sample_t             sample_ch1;
	sfdl_pkg::delay_t    delay_target;
	logic                block_last;
	logic                out_valid;
	logic                out_stall;
	sample_t             out_ch0;
	sample_t             out_ch1;
	logic                cfg_valid;
	logic                cfg_ready;
	sfdl_pkg::cfg_idx_t  cfg_index;
	sfdl_pkg::cfg_data_t cfg_data;

	delay_line_shadow shadow = new();

	// Traffic shaping knobs, set per phase by the stimulus process.
	bit tx_gaps  = 1'b1;
	bit rx_gaps  = 1'b1;
	bit quiet    = 1'b0;  // no idling at all on either side
	bit hold_req = 1'b0;  // ask the sink for one long stall

	always #6 clk = ~clk;

	smoothed_fractional_delay_line #(
		.STORE_DEPTH(HIST_LEN),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_ch0  (sample_ch0),
		.sample_ch1  (sample_ch1),
		.delay_target(delay_target),
		.block_last  (block_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_ch0     (out_ch0),
		.out_ch1     (out_ch1),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	function automatic frame_t frame_of(sample_t s0, sample_t s1, sfdl_pkg::delay_t t,
			logic l);
		frame_t fr;
		fr.ch0    = s0;
		fr.ch1    = s1;
		fr.target = t;
		fr.last   = l;
		return fr;
	endfunction

	// Mostly random bits, now and then a full-scale value.
	function automatic sample_t random_sample();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? PEAK_POS : PEAK_NEG;
		return sample_t'($urandom());
	endfunction

	// Keep most delays within reach of recent writes so the outputs carry
	// real data; the rest probe the clamp, zero delay and full 32-bit range.
	function automatic frame_t random_frame(int unsigned maxd);
		frame_t fr;
		int unsigned reach;
		reach  = (maxd < 64) ? maxd : 64;
		fr.ch0 = random_sample();
		fr.ch1 = random_sample();
		case ($urandom_range(0, 15))
			0:       fr.target = $urandom();
			1:       fr.target = '0;
			2:       fr.target = '1;
			3:       fr.target = (sfdl_pkg::delay_t'(maxd) << 16)
				- sfdl_pkg::delay_t'($urandom_range(0, 32'h3FFFF));
			default: fr.target = $urandom_range(0, ((reach + 1) << 16) - 1);
		endcase
		fr.last = ($urandom_range(0, 5) == 0);
		return fr;
	endfunction

	// Offer one frame, optionally after a short gap, and hold it until the
	// transfer. Valid stays high afterwards so frames can go back to back.
	task automatic send_frame(frame_t fr);
		if (tx_gaps && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_ch0   <= fr.ch0;
		sample_ch1   <= fr.ch1;
		delay_target <= fr.target;
		block_last   <= fr.last;
		do @(posedge clk); while (in_stall !== 1'b0);
		shadow.take_frame(fr);
	endtask

	// Drop valid and wait until every queued output has come out, then let
	// the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (shadow.outputs_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Valid is left high so back-to-back writes need no toggle.
	task automatic write_reg(sfdl_pkg::cfg_idx_t idx, sfdl_pkg::cfg_data_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		shadow.configure(idx, data);
	endtask

	task automatic load_settings(sfdl_pkg::maxd_t maxd, sfdl_pkg::rate_t rate, bit en);
		drain();
		write_reg(sfdl_pkg::REG_MAX_DELAY, sfdl_pkg::cfg_data_t'(maxd));
		write_reg(sfdl_pkg::REG_RATE, rate);
		write_reg(sfdl_pkg::REG_SMOOTH_EN, sfdl_pkg::cfg_data_t'(en));
		cfg_valid <= 1'b0;
	endtask

	// Output side: check every transfer against the oldest queued frame, then
	// pick the stall for the next cycle. A long hold requested by the stimulus
	// is counted out here while the sender keeps offering frames, so the block
	// backs up and stalls its input.
	initial begin : sink
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				shadow.check_output(out_ch0, out_ch1);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && rx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin : stimulus
		sfdl_pkg::maxd_t maxd;
		sfdl_pkg::rate_t rate;
		bit              en;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample_ch0   = '0;
		sample_ch1   = '0;
		delay_target = '0;
		block_last   = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = sfdl_pkg::REG_MAX_DELAY;
		cfg_data     = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: longest store, rate of one, smoothing on. The first
		// frame jumps straight to its target; zero delay returns the input.
		send_frame(frame_of(PEAK_POS, PEAK_NEG, 32'h0000_0000, 1'b0));
		send_frame(frame_of(PEAK_NEG, PEAK_POS, 32'h0000_8000, 1'b0));
		send_frame(frame_of(24'sh123456, -24'sh123456, 32'h0001_0000, 1'b0));
		send_frame(frame_of(PEAK_POS, PEAK_POS, 32'hFFFF_FFFF, 1'b0));
		send_frame(frame_of(-24'sd1, 24'sd1, 32'h0001_8000, 1'b1));
		send_frame(frame_of('0, '0, 32'h0002_4000, 1'b0));

		// Zero maximum, so the output follows the input; rate above one.
		load_settings('0, '1, 1'b1);
		send_frame(frame_of(PEAK_NEG, 24'sh2AAAAA, 32'hFFFF_FFFF, 1'b0));
		send_frame(frame_of(24'sh555555, PEAK_POS, 32'h0000_8000, 1'b1));
		send_frame(frame_of(PEAK_POS, PEAK_NEG, 32'h0000_0000, 1'b0));

		// Direct mode: the target is used as is, the smoother only moves at
		// block end.
		load_settings(16'd4, 17'h04000, 1'b0);
		send_frame(frame_of(24'sh100000, -24'sh100000, 32'h0000_0000, 1'b0));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0001_0000, 1'b0));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0002_8000, 1'b1));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0004_0000, 1'b0));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0005_0000, 1'b0));
		send_frame(frame_of(random_sample(), random_sample(), 32'hFFFF_FFFF, 1'b1));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0003_C000, 1'b0));

		// Shrink the store below the write pointer while running, with a slow
		// smoother picking up from the last block-end value.
		load_settings(16'd1, 17'h02000, 1'b1);
		send_frame(frame_of(random_sample(), random_sample(), 32'h0001_0000, 1'b0));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0000_8000, 1'b0));
		send_frame(frame_of(random_sample(), random_sample(), 32'hFFFF_FFFF, 1'b1));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0000_0000, 1'b0));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0000_C000, 1'b1));
		send_frame(frame_of(random_sample(), random_sample(), 32'h0001_0000, 1'b0));

		// Random phases, each with its own settings. The first two force the
		// smallest nonzero and the largest maximum; the last runs flat out.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 7))
				0:       maxd = '1;
				1:       maxd = '0;
				2:       maxd = 16'($urandom_range(1, 65535));
				default: maxd = 16'($urandom_range(1, 48));
			endcase
			if (ph == 0)
				maxd = 16'd1;
			if (ph == 1)
				maxd = '1;
			case ($urandom_range(0, 4))
				0:       rate = '0;
				1:       rate = sfdl_pkg::RATE_ONE;
				2:       rate = '1;
				3:       rate = 17'($urandom_range(0, 17'h1FFFF));
				default: rate = 17'($urandom_range(1, 17'h04000));
			endcase
			en = ($urandom_range(0, 2) != 0);
			load_settings(maxd, rate, en);
			quiet   = (ph == RAND_PHASES - 1);
			tx_gaps = ($urandom_range(0, 2) != 0);
			rx_gaps = ($urandom_range(0, 2) != 0);
			for (int k = 0; k < PHASE_FRAMES; k++) begin
				if (ph == 2 && k == 10)
					hold_req = 1'b1;
				if (ph == 4 && k == 64)
					drain();
				send_frame(random_frame(maxd));
			end
		end

		drain();
		if (shadow.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== smoothed_fractional_delay_line.f =====
rtl/sfdl_pkg.sv
rtl/sfdl_delay_ctl.sv
rtl/sfdl_lane.sv
rtl/smoothed_fractional_delay_line.sv
test/tb_smoothed_fractional_delay_line.sv
